// File: src/rgb_pixel_point_ops_defines.svh
// Assertion macros for the checker file of the pixel point-operation block
`ifndef RGB_PIXEL_POINT_OPS_DEFINES_SVH
`define RGB_PIXEL_POINT_OPS_DEFINES_SVH

// Check a property on every clock edge outside reset
`define RPO_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every clock edge, reset included
`define RPO_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: src/rpo_pkg.sv
// Package with the types and constants of the pixel point-operation block
package rpo_pkg;

  typedef enum logic [2:0] {
    FN_NEG    = 3'd0,
    FN_GRAY   = 3'd1,
    FN_TINT_B = 3'd2,
    FN_TINT_G = 3'd3,
    FN_TINT_R = 3'd4,
    FN_CON_UP = 3'd5,
    FN_CON_DN = 3'd6,
    FN_BANDS  = 3'd7
  } func_t;

  localparam logic [1:0] CH_BLUE  = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_RED   = 2'd2;

  localparam logic [1:0] CFG_PERCENT = 2'd0;
  localparam logic [1:0] CFG_WIDTH   = 2'd1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int PCT_W      = 7;
  localparam int WIDTH_W    = 13;
  localparam int COL_W      = 12;
  localparam int PIX_W      = 8;

  localparam logic [WIDTH_W-1:0] MAX_WIDTH   = 13'd4096;
  localparam logic [WIDTH_W-1:0] WIDTH_RESET = 13'd4096;
  localparam logic [PCT_W-1:0]   PCT_MAX     = 7'd100;
  localparam logic [PIX_W-1:0]   PIX_MID     = 8'd127;
  localparam logic [PIX_W-1:0]   PIX_SAT     = 8'd255;

  // floor(x / 3) = (x * DIV3_MUL) >> DIV3_SHIFT, exact for x < 2**16
  localparam int DIV3_MUL   = 43691;
  localparam int DIV3_SHIFT = 17;
  // floor(s / 3) = (s * MEAN_MUL) >> MEAN_SHIFT, exact for s <= 765
  localparam int MEAN_MUL   = 683;
  localparam int MEAN_SHIFT = 11;
  // floor(x / 100) = (x * DIV100_MUL) >> DIV100_SHIFT, exact for x <= 51000
  localparam int DIV100_MUL   = 83887;
  localparam int DIV100_SHIFT = 23;

  typedef struct packed {
    func_t            func;
    logic [PIX_W-1:0] mean;
    logic [1:0]       band;
  } ctl_t;

endpackage

// File: src/rgb_pixel_point_ops.sv
// Top level of the pixel point-operation pipeline
//
// Input channel: in_valid/in_stall with func, blue_in, green_in, red_in and
// column; one pixel is taken at each edge where in_valid is high and in_stall
// is low. Output channel: out_valid/out_stall with blue_out, green_out and
// red_out; one processed pixel leaves per transaction, in input order.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; index 0 is
// percent, index 1 is image_width, other indexes are ignored. cfg_ready is
// always high. Write configuration only while the pipeline is empty.
// Throughput is one pixel per cycle while out_stall is low. There are five
// register stages: input capture and channel sum, mean and band compare,
// factor multiply, divide-by-100 reciprocal multiply, and final select into
// the output register. Reset (rst, synchronous) empties all stages and sets
// percent to 0 and image_width to 4096. When out_stall is high, a full stage
// holds and empty stages ahead of it still fill; in_stall rises only when
// every stage is full.
module rgb_pixel_point_ops (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rpo_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rpo_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [2:0]                      func,
  input  logic [rpo_pkg::PIX_W-1:0]       blue_in,
  input  logic [rpo_pkg::PIX_W-1:0]       green_in,
  input  logic [rpo_pkg::PIX_W-1:0]       red_in,
  input  logic [rpo_pkg::COL_W-1:0]       column,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [rpo_pkg::PIX_W-1:0]       blue_out,
  output logic [rpo_pkg::PIX_W-1:0]       green_out,
  output logic [rpo_pkg::PIX_W-1:0]       red_out
);

  localparam int PW = rpo_pkg::PIX_W;
  localparam int WW = rpo_pkg::WIDTH_W;

  // configuration
  logic [rpo_pkg::PCT_W-1:0] percent;
  logic [WW-1:0]             image_width;
  logic [rpo_pkg::PCT_W-1:0] p_clip;
  logic [WW-1:0]             w_eff;
  logic [29:0]               lim1_prod;
  logic [30:0]               lim2_prod;
  logic [WW-1:0]             lim1;
  logic [WW-1:0]             lim2;
  logic [PW-1:0]             up;
  logic [PW-1:0]             dn;

  // stage valids and ready chain
  logic [5:1] v;
  logic [6:1] rdy;

  // stage 1
  rpo_pkg::func_t           s1_func;
  logic [PW-1:0]            s1_ch [3];
  logic [rpo_pkg::COL_W-1:0] s1_column;
  logic [PW+1:0]            s1_sum;

  // stage 2
  logic [19:0]    mean_prod;
  rpo_pkg::ctl_t  s2_ctl;
  logic [PW-1:0]  s2_ch [3];
  logic [1:0]     band_next;

  // stage 3
  rpo_pkg::ctl_t  s3_ctl;
  logic [PW-1:0]  s3_ch [3];
  logic [15:0]    s3_prod [3];
  logic [PW-1:0]  factor;

  // stage 4
  rpo_pkg::ctl_t  s4_ctl;
  logic [PW-1:0]  s4_ch [3];
  logic [PW:0]    s4_q [3];
  logic [32:0]    div_prod [3];

  // stage 5 (output)
  logic [PW-1:0]  y [3];
  logic [PW-1:0]  out_ch [3];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      percent     <= '0;
      image_width <= rpo_pkg::WIDTH_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        rpo_pkg::CFG_PERCENT: percent     <= cfg_data[rpo_pkg::PCT_W-1:0];
        rpo_pkg::CFG_WIDTH:   image_width <= cfg_data[WW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    p_clip = (percent > rpo_pkg::PCT_MAX) ? rpo_pkg::PCT_MAX : percent;
    w_eff  = (image_width > rpo_pkg::MAX_WIDTH) ? rpo_pkg::MAX_WIDTH : image_width;
    lim1_prod = 30'(w_eff) * 30'(rpo_pkg::DIV3_MUL);
    lim2_prod = 31'({w_eff, 1'b0}) * 31'(rpo_pkg::DIV3_MUL);
  end

  // hold derived configuration in registers
  always_ff @(posedge clk) begin
    lim1 <= lim1_prod[rpo_pkg::DIV3_SHIFT +: WW];
    lim2 <= lim2_prod[rpo_pkg::DIV3_SHIFT +: WW];
    up   <= PW'(rpo_pkg::PCT_MAX) + PW'(p_clip);
    dn   <= PW'(rpo_pkg::PCT_MAX) - PW'(p_clip);
  end

  always_comb begin
    rdy[6] = !out_stall;
    for (int k = 5; k >= 1; k--) begin
      rdy[k] = !v[k] || rdy[k+1];
    end
  end

  assign in_stall  = !rdy[1];
  assign out_valid = v[5];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[1]) v[1] <= in_valid;
      for (int k = 2; k <= 5; k++) begin
        if (rdy[k]) v[k] <= v[k-1];
      end
    end
  end

  // stage 1: capture and channel sum
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s1_func   <= rpo_pkg::func_t'(func);
      s1_ch[0]  <= blue_in;
      s1_ch[1]  <= green_in;
      s1_ch[2]  <= red_in;
      s1_column <= column;
      s1_sum    <= (PW+2)'(blue_in) + (PW+2)'(green_in) + (PW+2)'(red_in);
    end
  end

  // stage 2: mean and column band
  always_comb begin
    mean_prod = 20'(s1_sum) * 20'(rpo_pkg::MEAN_MUL);
    if ({1'b0, s1_column} < lim1) begin
      band_next = rpo_pkg::CH_RED;
    end else if ({1'b0, s1_column} < lim2) begin
      band_next = rpo_pkg::CH_GREEN;
    end else begin
      band_next = rpo_pkg::CH_BLUE;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s2_ctl.func <= s1_func;
      s2_ctl.mean <= mean_prod[rpo_pkg::MEAN_SHIFT +: PW];
      s2_ctl.band <= band_next;
      s2_ch       <= s1_ch;
    end
  end

  // stage 3: scale factor multiply
  always_comb begin
    if ((s2_ctl.func == rpo_pkg::FN_CON_UP && s2_ctl.mean < rpo_pkg::PIX_MID)
        || (s2_ctl.func == rpo_pkg::FN_CON_DN && s2_ctl.mean > rpo_pkg::PIX_MID)) begin
      factor = dn;
    end else begin
      factor = up;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      s3_ctl <= s2_ctl;
      s3_ch  <= s2_ch;
      for (int i = 0; i < 3; i++) begin
        s3_prod[i] <= 16'(s2_ch[i]) * 16'(factor);
      end
    end
  end

  // stage 4: divide by 100 through reciprocal multiply
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      div_prod[i] = 33'(s3_prod[i]) * 33'(rpo_pkg::DIV100_MUL);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      s4_ctl <= s3_ctl;
      s4_ch  <= s3_ch;
      for (int i = 0; i < 3; i++) begin
        s4_q[i] <= div_prod[i][rpo_pkg::DIV100_SHIFT +: PW+1];
      end
    end
  end

  // stage 5: select and saturate into the output register
  rpo_ch_sel u_sel_blue (
    .ctl   (s4_ctl),
    .ch_id (rpo_pkg::CH_BLUE),
    .c     (s4_ch[0]),
    .q     (s4_q[0]),
    .y     (y[0])
  );

  rpo_ch_sel u_sel_green (
    .ctl   (s4_ctl),
    .ch_id (rpo_pkg::CH_GREEN),
    .c     (s4_ch[1]),
    .q     (s4_q[1]),
    .y     (y[1])
  );

  rpo_ch_sel u_sel_red (
    .ctl   (s4_ctl),
    .ch_id (rpo_pkg::CH_RED),
    .c     (s4_ch[2]),
    .q     (s4_q[2]),
    .y     (y[2])
  );

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      out_ch <= y;
    end
  end

  assign blue_out  = out_ch[0];
  assign green_out = out_ch[1];
  assign red_out   = out_ch[2];

endmodule

// File: src/rpo_ch_sel.sv
// Final per-channel operation select and saturation
module rpo_ch_sel (
  input  rpo_pkg::ctl_t              ctl,
  input  logic [1:0]                 ch_id,
  input  logic [rpo_pkg::PIX_W-1:0]  c,
  input  logic [rpo_pkg::PIX_W:0]    q,
  output logic [rpo_pkg::PIX_W-1:0]  y
);

  logic [rpo_pkg::PIX_W-1:0] q_sat;
  logic [rpo_pkg::PIX_W-1:0] q_lo;
  logic [rpo_pkg::PIX_W-1:0] dbl;
  logic                      tint_hit;

  always_comb begin
    q_sat = q[rpo_pkg::PIX_W] ? rpo_pkg::PIX_SAT : q[rpo_pkg::PIX_W-1:0];
    q_lo  = (q > {1'b0, rpo_pkg::PIX_MID}) ? rpo_pkg::PIX_MID : q[rpo_pkg::PIX_W-1:0];
    dbl   = c[rpo_pkg::PIX_W-1] ? rpo_pkg::PIX_SAT : {c[rpo_pkg::PIX_W-2:0], 1'b0};
    tint_hit = (ctl.func == rpo_pkg::FN_TINT_B && ch_id == rpo_pkg::CH_BLUE)
            || (ctl.func == rpo_pkg::FN_TINT_G && ch_id == rpo_pkg::CH_GREEN)
            || (ctl.func == rpo_pkg::FN_TINT_R && ch_id == rpo_pkg::CH_RED);
    case (ctl.func)
      rpo_pkg::FN_NEG:  y = ~c;
      rpo_pkg::FN_GRAY: y = ctl.mean;
      rpo_pkg::FN_TINT_B, rpo_pkg::FN_TINT_G, rpo_pkg::FN_TINT_R: begin
        y = tint_hit ? q_sat : c;
      end
      rpo_pkg::FN_CON_UP: begin
        if (ctl.mean > rpo_pkg::PIX_MID) begin
          y = q_sat;
        end else if (ctl.mean < rpo_pkg::PIX_MID) begin
          y = q[rpo_pkg::PIX_W-1:0];
        end else begin
          y = c;
        end
      end
      rpo_pkg::FN_CON_DN: begin
        if (ctl.mean <= rpo_pkg::PIX_MID) begin
          y = q_lo;
        end else if (q < {1'b0, rpo_pkg::PIX_MID}) begin
          y = rpo_pkg::PIX_MID;
        end else begin
          y = q[rpo_pkg::PIX_W-1:0];
        end
      end
      rpo_pkg::FN_BANDS: y = (ch_id == ctl.band) ? dbl : c;
      default:           y = c;
    endcase
  end

endmodule

// File: src/rpo_checker.sv
// Port-level checker for the pixel point-operation block, with its bind
`include "rgb_pixel_point_ops_defines.svh"

module rpo_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [rpo_pkg::PIX_W-1:0]       blue_out,
  input logic [rpo_pkg::PIX_W-1:0]       green_out,
  input logic [rpo_pkg::PIX_W-1:0]       red_out
);

  logic [3*rpo_pkg::PIX_W-1:0] out_pix;

  assign out_pix = {blue_out, green_out, red_out};

  `RPO_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "stalled result dropped")
  `RPO_ASSERT(a_out_stable, out_valid && out_stall |=> $stable(out_pix), "stalled result changed")
  `RPO_ASSERT(a_stall_full, in_stall |-> out_valid && out_stall, "input stalled with room")
  `RPO_ASSERT_ALWAYS(a_reset_empty, $past(rst) |-> !out_valid, "result present after reset")

endmodule

bind rgb_pixel_point_ops rpo_checker u_rpo_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .blue_out  (blue_out),
  .green_out (green_out),
  .red_out   (red_out)
);

// File: tb/rgb_pixel_point_ops_tb.sv
// Self-checking testbench for the pixel point-operation pipeline
module rgb_pixel_point_ops_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rpo_pkg::*;

  localparam int LATENCY         = 5;
  localparam int SETTLE_CYCLES   = LATENCY + 3;
  localparam int TAIL_CYCLES     = 4 * LATENCY;
  localparam int IDLE_LIMIT      = 2000;
  localparam int N_PHASES        = 12;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int PCT_BASE        = 100;
  localparam int COL_MAX         = (1 << COL_W) - 1;
  localparam int CFG_DATA_MAX    = (1 << CFG_DATA_W) - 1;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef struct packed {
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
  } pixel_t;

  class pixel_scoreboard;
    logic [PCT_W-1:0]   pct;
    logic [WIDTH_W-1:0] img_width;
    pixel_t             expected_q[$];
    int                 n_in;
    int                 n_out;
    int                 n_err;

    function new();
      pct       = '0;
      img_width = WIDTH_RESET;
      n_in      = 0;
      n_out     = 0;
      n_err     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_PERCENT) begin
        pct = data[PCT_W-1:0];
      end else if (idx == CFG_WIDTH) begin
        img_width = data[WIDTH_W-1:0];
      end
    endfunction

    function int unsigned eff_width();
      return 32'((img_width > MAX_WIDTH) ? MAX_WIDTH : img_width);
    endfunction

    function int unsigned scaled(int unsigned c, int unsigned factor);
      return (c * factor) / PCT_BASE;
    endfunction

    function int unsigned clip(int unsigned x, int unsigned lim);
      return (x > lim) ? lim : x;
    endfunction

    function pixel_t apply_point_op(func_t f, pixel_t px, logic [COL_W-1:0] col);
      int unsigned ch[3];
      int unsigned p;
      int unsigned up;
      int unsigned dn;
      int unsigned w;
      int unsigned mean;
      int unsigned sel;
      pixel_t      res;
      p            = 32'((pct > PCT_MAX) ? PCT_MAX : pct);
      up           = PCT_BASE + p;
      dn           = PCT_BASE - p;
      w            = eff_width();
      ch[CH_BLUE]  = 32'(px.blue);
      ch[CH_GREEN] = 32'(px.green);
      ch[CH_RED]   = 32'(px.red);
      mean         = (ch[CH_BLUE] + ch[CH_GREEN] + ch[CH_RED]) / 3;
      case (f)
        FN_NEG: begin
          foreach (ch[i]) ch[i] = PIX_SAT - ch[i];
        end
        FN_GRAY: begin
          foreach (ch[i]) ch[i] = mean;
        end
        FN_TINT_B, FN_TINT_G, FN_TINT_R: begin
          sel = 32'((f == FN_TINT_B) ? CH_BLUE : (f == FN_TINT_G) ? CH_GREEN : CH_RED);
          ch[sel] = clip(scaled(ch[sel], up), PIX_SAT);
        end
        FN_CON_UP: begin
          if (mean > PIX_MID) begin
            foreach (ch[i]) ch[i] = clip(scaled(ch[i], up), PIX_SAT);
          end else if (mean < PIX_MID) begin
            foreach (ch[i]) ch[i] = scaled(ch[i], dn);
          end
        end
        FN_CON_DN: begin
          if (mean <= PIX_MID) begin
            foreach (ch[i]) ch[i] = clip(scaled(ch[i], up), PIX_MID);
          end else begin
            foreach (ch[i]) ch[i] = (scaled(ch[i], dn) < PIX_MID) ? PIX_MID : scaled(ch[i], dn);
          end
        end
        default: begin
          if (col < w / 3) begin
            sel = 32'(CH_RED);
          end else if (col < (w * 2) / 3) begin
            sel = 32'(CH_GREEN);
          end else begin
            sel = 32'(CH_BLUE);
          end
          ch[sel] = clip(ch[sel] * 2, PIX_SAT);
        end
      endcase
      res.blue  = PIX_W'(ch[CH_BLUE]);
      res.green = PIX_W'(ch[CH_GREEN]);
      res.red   = PIX_W'(ch[CH_RED]);
      return res;
    endfunction

    function void note_input(func_t f, pixel_t px, logic [COL_W-1:0] col);
      n_in++;
      expected_q.push_back(apply_point_op(f, px, col));
    endfunction

    function void check_result(pixel_t got);
      pixel_t want;
      n_out++;
      if (expected_q.size() == 0) begin
        $error("unexpected pixel: blue %0d green %0d red %0d", got.blue, got.green, got.red);
        n_err++;
        return;
      end
      want = expected_q.pop_front();
      if (got.blue !== want.blue) begin
        $error("blue_out: expected %0d, actual %0d", want.blue, got.blue);
        n_err++;
      end
      if (got.green !== want.green) begin
        $error("green_out: expected %0d, actual %0d", want.green, got.green);
        n_err++;
      end
      if (got.red !== want.red) begin
        $error("red_out: expected %0d, actual %0d", want.red, got.red);
        n_err++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  logic [2:0]            func      = '0;
  logic [PIX_W-1:0]      blue_in   = '0;
  logic [PIX_W-1:0]      green_in  = '0;
  logic [PIX_W-1:0]      red_in    = '0;
  logic [COL_W-1:0]      column    = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [PIX_W-1:0]      blue_out;
  logic [PIX_W-1:0]      green_out;
  logic [PIX_W-1:0]      red_out;

  pixel_scoreboard sb = new();
  int              n_settings  = 0;
  int              idle_cycles = 0;
  int              stall_left  = 0;
  int              stall_pct   = 0;

  rgb_pixel_point_ops dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .blue_in   (blue_in),
    .green_in  (green_in),
    .red_in    (red_in),
    .column    (column),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .blue_out  (blue_out),
    .green_out (green_out),
    .red_out   (red_out)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) begin
        sb.note_input(func_t'(func), pixel_t'{blue_in, green_in, red_in}, column);
      end
      if (out_valid && !out_stall) sb.check_result(pixel_t'{blue_out, green_out, red_out});
    end
  end

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_left <= $urandom_range(10, 150);
      case ($urandom_range(0, 4))
        0, 1:    stall_pct <= 0;
        2:       stall_pct <= 30;
        3:       stall_pct <= 60;
        default: stall_pct <= 85;
      endcase
    end else begin
      stall_left <= stall_left - 1;
    end
    out_stall <= ($urandom_range(1, 100) <= stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (cfg_valid && cfg_ready) || (in_valid && !in_stall) ||
        (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_pixel(func_t f, logic [PIX_W-1:0] b, logic [PIX_W-1:0] g,
                            logic [PIX_W-1:0] r, logic [COL_W-1:0] col);
    func     <= f;
    blue_in  <= b;
    green_in <= g;
    red_in   <= r;
    column   <= col;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic configure(logic [CFG_DATA_W-1:0] pct_data, logic [CFG_DATA_W-1:0] width_data);
    logic [CFG_IDX_W-1:0]  idx[3];
    logic [CFG_DATA_W-1:0] data[3];
    int                    pos;
    int                    j;
    int                    i;
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() > 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    pos = $urandom_range(0, 2);
    j   = 0;
    for (i = 0; i < 3; i++) begin
      if (i == pos) begin
        idx[i]  = $urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B;
        data[i] = CFG_DATA_W'($urandom_range(0, CFG_DATA_MAX));
      end else begin
        idx[i]  = (j == 0) ? CFG_PERCENT : CFG_WIDTH;
        data[i] = (j == 0) ? pct_data : width_data;
        j++;
      end
    end
    for (i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= data[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  initial begin
    func_t            f;
    logic [PIX_W-1:0] b;
    logic [PIX_W-1:0] g;
    logic [PIX_W-1:0] r;
    logic [CFG_DATA_W-1:0] p_data;
    logic [CFG_DATA_W-1:0] w_data;
    int               col;
    int               w;
    int               gap;
    int               burst_left;
    int               phase;
    int               k;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_pixel(FN_NEG, 8'd0, 8'd128, 8'd255, 12'd0);
    send_pixel(FN_TINT_R, 8'd255, 8'd255, 8'd255, 12'd4095);
    send_pixel(FN_BANDS, 8'd200, 8'd100, 8'd100, 12'd1364);
    send_pixel(FN_BANDS, 8'd200, 8'd100, 8'd100, 12'd1365);

    configure(13'd37, 13'd30);
    send_pixel(FN_NEG, 8'd255, 8'd255, 8'd255, 12'd4095);
    send_pixel(FN_GRAY, 8'd255, 8'd255, 8'd255, 12'd0);
    send_pixel(FN_GRAY, 8'd1, 8'd1, 8'd0, 12'd0);
    send_pixel(FN_TINT_B, 8'd255, 8'd10, 8'd20, 12'd0);
    send_pixel(FN_TINT_G, 8'd30, 8'd100, 8'd40, 12'd0);
    send_pixel(FN_TINT_R, 8'd30, 8'd50, 8'd200, 12'd0);
    send_pixel(FN_CON_UP, 8'd127, 8'd127, 8'd127, 12'd0);
    send_pixel(FN_CON_UP, 8'd128, 8'd128, 8'd128, 12'd0);
    send_pixel(FN_CON_UP, 8'd126, 8'd127, 8'd126, 12'd0);
    send_pixel(FN_CON_DN, 8'd127, 8'd127, 8'd127, 12'd0);
    send_pixel(FN_CON_DN, 8'd255, 8'd0, 8'd129, 12'd0);
    send_pixel(FN_CON_DN, 8'd0, 8'd0, 8'd0, 12'd0);
    send_pixel(FN_BANDS, 8'd100, 8'd100, 8'd200, 12'd9);
    send_pixel(FN_BANDS, 8'd100, 8'd100, 8'd200, 12'd10);
    send_pixel(FN_BANDS, 8'd100, 8'd200, 8'd100, 12'd19);
    send_pixel(FN_BANDS, 8'd100, 8'd200, 8'd100, 12'd20);
    send_pixel(FN_BANDS, 8'd200, 8'd100, 8'd100, 12'd29);
    send_pixel(FN_BANDS, 8'd200, 8'd100, 8'd100, 12'd30);
    send_pixel(FN_BANDS, 8'd200, 8'd100, 8'd100, 12'd4095);

    burst_left = 0;
    for (phase = 0; phase < N_PHASES; phase++) begin
      case (phase)
        0: begin p_data = 13'd0;      w_data = 13'd1;    end
        1: begin p_data = 13'd100;    w_data = 13'd2;    end
        2: begin p_data = 13'd127;    w_data = 13'd3;    end
        3: begin p_data = 13'h1FFF;   w_data = 13'd0;    end
        4: begin p_data = 13'd1;      w_data = 13'd4096; end
        5: begin p_data = 13'd99;     w_data = 13'd8191; end
        6: begin p_data = 13'h0085;   w_data = 13'd4097; end
        7: begin p_data = 13'd50;     w_data = 13'd6;    end
        default: begin
          p_data = CFG_DATA_W'($urandom_range(0, 1) ? $urandom_range(0, 100)
                                                    : $urandom_range(0, CFG_DATA_MAX));
          w_data = CFG_DATA_W'($urandom_range(0, 1) ? $urandom_range(1, 64)
                                                    : $urandom_range(0, CFG_DATA_MAX));
        end
      endcase
      configure(p_data, w_data);

      for (k = 0; k < ITEMS_PER_PHASE; k++) begin
        f = func_t'($urandom_range(0, 7));
        case ($urandom_range(0, 9))
          6: begin
            b = $urandom_range(0, 1) ? PIX_SAT : 8'd0;
            g = $urandom_range(0, 1) ? PIX_SAT : 8'd0;
            r = $urandom_range(0, 1) ? PIX_SAT : 8'd0;
          end
          7: begin
            b = PIX_W'($urandom_range(120, 134));
            g = PIX_W'($urandom_range(120, 134));
            r = PIX_W'($urandom_range(120, 134));
          end
          8: begin
            b = PIX_W'($urandom_range(0, 255));
            g = b;
            r = b;
          end
          default: begin
            b = PIX_W'($urandom_range(0, 255));
            g = PIX_W'($urandom_range(0, 255));
            r = PIX_W'($urandom_range(0, 255));
          end
        endcase
        if (f == FN_BANDS && $urandom_range(0, 1)) begin
          w = sb.eff_width();
          case ($urandom_range(0, 2))
            0:       col = w / 3;
            1:       col = (w * 2) / 3;
            default: col = w;
          endcase
          col = col + int'($urandom_range(0, 2)) - 1;
          if (col < 0) col = 0;
          if (col > COL_MAX) col = COL_MAX;
        end else begin
          col = $urandom_range(0, COL_MAX);
        end
        send_pixel(f, b, g, r, COL_W'(col));

        if (burst_left > 0) begin
          burst_left--;
        end else begin
          gap = $urandom_range(1, 8);
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 150) : $urandom_range(0, 20);
        end
      end
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() > 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Checked %0d pixels under %0d register settings, all eight operations,",
             sb.n_out, n_settings);
    $display("band edges and clipped registers, with sender gaps and receiver stalls.");
    if (sb.n_err == 0 && sb.pending() == 0 && sb.n_in == sb.n_out) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
